// ===== rtl/termcap_escape_decoder_top_defines.svh =====
// Assertion macros shared by the decoder RTL.
`ifndef TERMCAP_ESCAPE_DECODER_TOP_DEFINES_SVH
`define TERMCAP_ESCAPE_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, checked on the rising edge of aclk outside reset.
`define TED_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising edge of aclk outside reset.
`define TED_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ted_pkg.sv =====
package ted_pkg;

    localparam int CAP_W = 13;
    localparam logic [CAP_W-1:0] CAP_RESET = 13'd100;
    localparam logic [CAP_W-1:0] COUNT_MAX = 13'h1FFF;

    // Result status codes.
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_BAD = 2'd1;
    localparam logic [1:0] ST_OVF = 2'd2;

    // Characters of the escape syntax.
    localparam logic [7:0] CHR_NUL    = 8'h00;
    localparam logic [7:0] CHR_COLON  = 8'h3A;
    localparam logic [7:0] CHR_ZERO   = 8'h30;
    localparam logic [7:0] CHR_SEVEN  = 8'h37;
    localparam logic [7:0] CHR_BSLASH = 8'h5C;
    localparam logic [7:0] CHR_CARET  = 8'h5E;
    localparam logic [7:0] CHR_UP_E   = 8'h45;
    localparam logic [7:0] CHR_LO_N   = 8'h6E;
    localparam logic [7:0] CHR_LO_R   = 8'h72;
    localparam logic [7:0] CHR_LO_T   = 8'h74;
    localparam logic [7:0] CHR_LO_B   = 8'h62;
    localparam logic [7:0] CHR_LO_F   = 8'h66;
    localparam logic [7:0] CHR_LO_A   = 8'h61;
    localparam logic [7:0] CHR_LO_Z   = 8'h7A;

    // Decoded control bytes.
    localparam logic [7:0] BYTE_ESC = 8'h1B;
    localparam logic [7:0] BYTE_LF  = 8'h0A;
    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_TAB = 8'h09;
    localparam logic [7:0] BYTE_BS  = 8'h08;
    localparam logic [7:0] BYTE_FF  = 8'h0C;

    // Offsets for caret pairs: lower to upper case, then control code.
    localparam logic [7:0] CASE_OFFSET  = 8'd32;
    localparam logic [7:0] CARET_OFFSET = 8'd64;

endpackage

// ===== rtl/termcap_escape_decoder_top.sv =====
// Termcap escape decoder: takes one raw byte of a capability string per word on the s_ channel
// and returns the decoded bytes on the m_ channel, ending each string with a word that has
// m_is_last set and m_status giving ok, bad escape or buffer overflow. Bytes that open
// an escape (backslash, caret, octal digits) give no word of their own. A byte passes an input
// register and then a result register on its way to the m_ side; one byte is accepted every
// cycle while the m_ side keeps up, and the phase, octal
// and count state is updated in the single step between the two registers. cfg_wr_data sets
// the buffer capacity (reset value 100) and is to be written only while no string is in flight.
`include "termcap_escape_decoder_top_defines.svh"

module termcap_escape_decoder_top (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [ted_pkg::CAP_W-1:0]  cfg_wr_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [7:0]                 s_in_byte,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [7:0]                 m_out_byte,
    output logic                       m_is_last,
    output logic [1:0]                 m_status
);

    typedef enum logic [2:0] {
        PH_NORMAL = 3'd0,
        PH_BSLASH = 3'd1,
        PH_OCT1   = 3'd2,
        PH_OCT2   = 3'd3,
        PH_CARET  = 3'd4,
        PH_SKIP   = 3'd5
    } phase_t;

    phase_t                      phase_reg, phase_next;
    logic [7:0]                  acc_reg, acc_next;
    logic [ted_pkg::CAP_W-1:0]   cnt_reg, cnt_next;
    logic [ted_pkg::CAP_W-1:0]   cap_reg;

    logic                        in_vld_reg;
    logic [7:0]                  in_byte_reg;
    logic                        out_vld_reg;
    logic [7:0]                  out_byte_reg;
    logic                        out_last_reg;
    logic [1:0]                  out_status_reg;

    logic                        res_valid;
    logic [7:0]                  res_byte;
    logic                        res_last;
    logic [1:0]                  res_status;
    logic                        res_data;
    logic                        term;
    logic                        is_oct;
    logic [2:0]                  digit;
    logic [7:0]                  upper;
    logic                        proceed;

    assign term   = (in_byte_reg == ted_pkg::CHR_COLON) || (in_byte_reg == ted_pkg::CHR_NUL);
    assign is_oct = (in_byte_reg >= ted_pkg::CHR_ZERO) && (in_byte_reg <= ted_pkg::CHR_SEVEN);
    assign digit  = in_byte_reg[2:0];
    assign upper  = ((in_byte_reg >= ted_pkg::CHR_LO_A) && (in_byte_reg <= ted_pkg::CHR_LO_Z))
                  ? in_byte_reg - ted_pkg::CASE_OFFSET : in_byte_reg;

    always_comb begin
        res_valid  = 1'b0;
        res_byte   = 8'd0;
        res_last   = 1'b0;
        res_status = ted_pkg::ST_OK;
        res_data   = 1'b0;
        phase_next = phase_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;

        unique case (phase_reg)
            PH_SKIP: begin
                if (term) begin
                    phase_next = PH_NORMAL;
                end
            end
            PH_BSLASH: begin
                phase_next = PH_NORMAL;
                res_data   = 1'b1;
                case (in_byte_reg)
                    ted_pkg::CHR_UP_E:   res_byte = ted_pkg::BYTE_ESC;
                    ted_pkg::CHR_LO_N:   res_byte = ted_pkg::BYTE_LF;
                    ted_pkg::CHR_LO_R:   res_byte = ted_pkg::BYTE_CR;
                    ted_pkg::CHR_LO_T:   res_byte = ted_pkg::BYTE_TAB;
                    ted_pkg::CHR_LO_B:   res_byte = ted_pkg::BYTE_BS;
                    ted_pkg::CHR_LO_F:   res_byte = ted_pkg::BYTE_FF;
                    ted_pkg::CHR_BSLASH: res_byte = ted_pkg::CHR_BSLASH;
                    ted_pkg::CHR_CARET:  res_byte = ted_pkg::CHR_CARET;
                    default: begin
                        res_data = 1'b0;
                        if (is_oct) begin
                            acc_next   = {5'd0, digit};
                            phase_next = PH_OCT1;
                        end else begin
                            res_valid  = 1'b1;
                            res_last   = 1'b1;
                            res_status = ted_pkg::ST_BAD;
                            cnt_next   = '0;
                            acc_next   = 8'd0;
                            phase_next = term ? PH_NORMAL : PH_SKIP;
                        end
                    end
                endcase
            end
            PH_OCT1, PH_OCT2: begin
                if (!is_oct) begin
                    res_valid  = 1'b1;
                    res_last   = 1'b1;
                    res_status = ted_pkg::ST_BAD;
                    cnt_next   = '0;
                    acc_next   = 8'd0;
                    phase_next = term ? PH_NORMAL : PH_SKIP;
                end else if (phase_reg == PH_OCT1) begin
                    // Shifting by three and keeping eight bits drops the top three.
                    acc_next   = {acc_reg[4:0], digit};
                    phase_next = PH_OCT2;
                end else begin
                    res_data   = 1'b1;
                    res_byte   = {acc_reg[4:0], digit};
                    acc_next   = 8'd0;
                    phase_next = PH_NORMAL;
                end
            end
            PH_CARET: begin
                phase_next = PH_NORMAL;
                if (in_byte_reg == ted_pkg::CHR_NUL) begin
                    res_valid  = 1'b1;
                    res_last   = 1'b1;
                    res_status = (cnt_reg >= cap_reg) ? ted_pkg::ST_OVF : ted_pkg::ST_OK;
                    cnt_next   = '0;
                end else begin
                    res_data = 1'b1;
                    res_byte = upper - ted_pkg::CARET_OFFSET;
                end
            end
            default: begin
                phase_next = PH_NORMAL;
                if (term) begin
                    res_valid  = 1'b1;
                    res_last   = 1'b1;
                    res_status = (cnt_reg >= cap_reg) ? ted_pkg::ST_OVF : ted_pkg::ST_OK;
                    cnt_next   = '0;
                end else if (in_byte_reg == ted_pkg::CHR_BSLASH) begin
                    phase_next = PH_BSLASH;
                end else if (in_byte_reg == ted_pkg::CHR_CARET) begin
                    phase_next = PH_CARET;
                end else begin
                    res_data = 1'b1;
                    res_byte = in_byte_reg;
                end
            end
        endcase

        // A data word counts towards the buffer, saturating at the counter's top value.
        if (res_data) begin
            res_valid = 1'b1;
            if (cnt_reg != ted_pkg::COUNT_MAX) begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    // A byte leaves the input register when its word, if any, has room in the result register.
    assign proceed = in_vld_reg && (!res_valid || !out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || proceed;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_NORMAL;
            acc_reg     <= 8'd0;
            cnt_reg     <= '0;
            cap_reg     <= ted_pkg::CAP_RESET;
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                in_vld_reg <= 1'b1;
            end else if (proceed) begin
                in_vld_reg <= 1'b0;
            end
            if (proceed) begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                cnt_reg   <= cnt_next;
            end
            if (proceed && res_valid) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
        end
        if (proceed && res_valid) begin
            out_byte_reg   <= res_byte;
            out_last_reg   <= res_last;
            out_status_reg <= res_status;
        end
    end

    assign m_valid    = out_vld_reg;
    assign m_out_byte = out_byte_reg;
    assign m_is_last  = out_last_reg;
    assign m_status   = out_status_reg;

    `TED_ASSERT_NOW(a_data_status_ok, out_vld_reg && !out_last_reg, out_status_reg == ted_pkg::ST_OK, "data word with non-ok status")
    `TED_ASSERT_NEXT(a_end_clears_count, proceed && res_valid && res_last, cnt_reg == '0, "count not cleared after end of string")
    `TED_ASSERT_NEXT(a_input_held, in_vld_reg && !proceed, in_vld_reg && $stable(in_byte_reg), "stalled input byte lost or changed")
    `TED_ASSERT_NOW(a_skip_silent, in_vld_reg && phase_reg == PH_SKIP, !res_valid, "word produced while skipping")

endmodule
